/* rtl/core/dna_kmer_rolling_encoder_macros.svh */
// Assertion helpers for the checker file.
`ifndef DNA_KMER_ROLLING_ENCODER_MACROS_SVH
`define DNA_KMER_ROLLING_ENCODER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define DKRE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dkre check failed");

// next-cycle implication, sampled on clk, off while in reset
`define DKRE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dkre check failed");

`endif

/* rtl/core/dkre_pkg.sv */
`default_nettype none
package dkre_pkg;
	localparam int KLEN_W     = 5;
	localparam int KMER_MAX   = 16;
	localparam int KMER_RST   = 12;
	localparam int CHAR_W     = 8;
	localparam int WORD_W     = 32;
	localparam int POS_W      = 5;   // 32 bases per plane word
	localparam int DATA_W     = 5 * WORD_W;

	localparam logic FUNC_BASE  = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
	localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
	localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;
	localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

	localparam logic [1:0] CODE_A = 2'd0;
	localparam logic [1:0] CODE_C = 2'd1;
	localparam logic [1:0] CODE_G = 2'd2;
	localparam logic [1:0] CODE_T = 2'd3;

	typedef struct packed {
		logic unknown;
		logic [1:0] code;
	} base_code_t;

	// bit 0 is kmer_valid
	typedef struct packed {
		logic packed_word_valid;
		logic plane_words_valid;
		logic kmer_sampled;
		logic kmer_valid;
	} out_flags_t;

	function automatic base_code_t decode_base(input logic [CHAR_W-1:0] ch);
		logic [CHAR_W-1:0] up;
		base_code_t r;
		up = ch;
		if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) begin
			up = ch - CASE_DIFF;
		end
		r.unknown = 1'b0;
		case (up)
			CHAR_A: r.code = CODE_A;
			CHAR_C: r.code = CODE_C;
			CHAR_G: r.code = CODE_G;
			CHAR_T: r.code = CODE_T;
			default: begin
				r.code = CODE_A;
				r.unknown = 1'b1;
			end
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

/* rtl/core/dna_kmer_rolling_encoder.sv */
// Result path: input register, then result register; an item moves on when the result register is free.
// Throughput: one item per cycle while the result is not stalled; the k-mer and word accumulators update per item.
// A stalled result register holds; the input register takes one more item, then s_tready drops.
// Reset (arst_n low, async): stream state cleared, kmer_length back to 12, no result held.
`default_nettype none
module dna_kmer_rolling_encoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dkre_pkg::KLEN_W-1:0]   cfg_data,    // kmer_length
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dkre_pkg::CHAR_W-1:0]   s_tdata,     // base_char
	input  logic [0:0]                    s_tuser,     // func
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// kmer_value, plane_low_word, plane_high_word, unknown_word, packed_word
	output logic [dkre_pkg::DATA_W-1:0]   m_tdata,
	// kmer_valid, kmer_sampled, plane_words_valid, packed_word_valid
	output logic [3:0]                    m_tuser
);
	import dkre_pkg::*;

	logic [KLEN_W-1:0] klen_q;
	logic              valid_s1;
	logic              func_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              out_free;
	logic              fire_s1;

	logic [WORD_W-1:0] shift_q, low_q, high_q, unk_q, pack_q;
	logic [KLEN_W-1:0] fill_q;
	logic [POS_W-1:0]  pos_q;

	logic [WORD_W-1:0] shift_d, low_d, high_d, unk_d, pack_d;
	logic [KLEN_W-1:0] fill_d;
	logic [POS_W-1:0]  pos_d;

	logic              m_valid_q;
	logic [DATA_W-1:0] m_data_q;
	out_flags_t        m_flags_q;
	logic [WORD_W-1:0] kmer_r, plow_r, phigh_r, unk_r, pack_r;
	out_flags_t        flags_r;

	assign cfg_ready = 1'b1;
	assign out_free  = !m_valid_q || m_tready;
	assign fire_s1   = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || out_free;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign m_tuser   = m_flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= KLEN_W'(KMER_RST);
		end else if (cfg_valid && cfg_ready) begin
			klen_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser[0];
			char_s1 <= s_tdata;
		end
	end

	always_comb begin
		base_code_t        bc;
		logic [KLEN_W-1:0] keff;
		logic [KLEN_W-1:0] kmin1;
		logic [KLEN_W-1:0] sh_amt;
		bc      = decode_base(char_s1);
		keff    = klen_q;
		if (klen_q == '0) begin
			keff = KLEN_W'(1);
		end else if (klen_q > KLEN_W'(KMER_MAX)) begin
			keff = KLEN_W'(KMER_MAX);
		end
		kmin1   = keff - KLEN_W'(1);
		sh_amt  = {kmin1[3:0], 1'b0};

		shift_d = shift_q;
		fill_d  = fill_q;
		pos_d   = pos_q;
		low_d   = low_q;
		high_d  = high_q;
		unk_d   = unk_q;
		pack_d  = pack_q;
		kmer_r  = '0;
		plow_r  = '0;
		phigh_r = '0;
		unk_r   = '0;
		pack_r  = '0;
		flags_r = '0;

		if (func_s1 == FUNC_FLUSH) begin
			if (pos_q != '0) begin
				plow_r  = low_q;
				phigh_r = high_q;
				unk_r   = unk_q;
				flags_r.plane_words_valid = 1'b1;
			end
			if (pos_q[3:0] != 4'd0) begin
				pack_r = pack_q;
				flags_r.packed_word_valid = 1'b1;
			end
			shift_d = '0;
			fill_d  = '0;
			pos_d   = '0;
			low_d   = '0;
			high_d  = '0;
			unk_d   = '0;
			pack_d  = '0;
		end else begin
			if (!bc.unknown) begin
				shift_d = (shift_q >> 2) | (WORD_W'(bc.code) << sh_amt);
				if (fill_q < KLEN_W'(KMER_MAX)) begin
					fill_d = fill_q + KLEN_W'(1);
				end
				low_d  = low_q  | (WORD_W'(bc.code[0]) << pos_q);
				high_d = high_q | (WORD_W'(bc.code[1]) << pos_q);
				pack_d = pack_q | (WORD_W'(bc.code) << {pos_q[3:0], 1'b0});
				if (fill_d >= keff) begin
					flags_r.kmer_valid   = 1'b1;
					flags_r.kmer_sampled = (2'(pos_q[1:0] + 2'd1 - keff[1:0]) == 2'd0);
				end
			end else begin
				shift_d = '0;
				fill_d  = '0;
				unk_d   = unk_q | (WORD_W'(1) << pos_q);
			end
			kmer_r = shift_d;
			// emit and restart the plane words on the last of 32 bases
			if (pos_q == '1) begin
				plow_r  = low_d;
				phigh_r = high_d;
				unk_r   = unk_d;
				flags_r.plane_words_valid = 1'b1;
				low_d  = '0;
				high_d = '0;
				unk_d  = '0;
			end
			if (pos_q[3:0] == 4'hF) begin
				pack_r = pack_d;
				flags_r.packed_word_valid = 1'b1;
				pack_d = '0;
			end
			pos_d = pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			fill_q  <= '0;
			pos_q   <= '0;
			low_q   <= '0;
			high_q  <= '0;
			unk_q   <= '0;
			pack_q  <= '0;
		end else if (fire_s1) begin
			shift_q <= shift_d;
			fill_q  <= fill_d;
			pos_q   <= pos_d;
			low_q   <= low_d;
			high_q  <= high_d;
			unk_q   <= unk_d;
			pack_q  <= pack_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			m_data_q  <= {pack_r, unk_r, phigh_r, plow_r, kmer_r};
			m_flags_q <= flags_r;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/dkre_checker.sv */
`default_nettype none
`include "dna_kmer_rolling_encoder_macros.svh"
module dkre_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [dkre_pkg::DATA_W-1:0] m_tdata,
	input logic [3:0]                  m_tuser
);
	import dkre_pkg::*;

	out_flags_t fl;
	assign fl = m_tuser;

	// hold a stalled result
	`DKRE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`DKRE_ASSERT_NOW(a_sampled, m_tvalid && fl.kmer_sampled, fl.kmer_valid)
	`DKRE_ASSERT_NOW(a_planes_zero, m_tvalid && !fl.plane_words_valid, m_tdata[4*WORD_W-1:WORD_W] == '0)
	`DKRE_ASSERT_NOW(a_pack_zero, m_tvalid && !fl.packed_word_valid, m_tdata[5*WORD_W-1:4*WORD_W] == '0)
endmodule

bind dna_kmer_rolling_encoder dkre_checker u_dkre_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
